FILE: hw/rtl/aescbc_pkg.sv
// shared types, constants and round functions for the aes-128 cbc decrypt core
// depends on nothing; every other file imports it
package aescbc_pkg;

  localparam int unsigned BLK_W  = 128;
  localparam int unsigned ROUNDS = 10;
  localparam int unsigned NKEYS  = ROUNDS + 1;
  localparam int unsigned CFG_W  = 64;
  localparam int unsigned IDX_W  = 3;

  typedef logic [BLK_W-1:0] blk_t;
  typedef logic [NKEYS-1:0][BLK_W-1:0] rkeys_t;
  typedef logic [7:0] box_t [256];

  typedef enum logic [IDX_W-1:0] {
    CFG_KEY_HI = 3'd0,
    CFG_KEY_LO = 3'd1,
    CFG_IV_HI  = 3'd2,
    CFG_IV_LO  = 3'd3
  } cfg_idx_t;

  typedef struct packed {
    logic vld;
  } stg_ctl_t;

  localparam box_t SBOX = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // inverse table built at elaboration from the forward one
  function automatic box_t invert_box(box_t f);
    box_t r;
    for (int i = 0; i < 256; i++) begin
      r[f[i]] = 8'(i);
    end
    return r;
  endfunction

  localparam box_t INV_SBOX = invert_box(SBOX);

  function automatic logic [7:0] rcon(logic [3:0] i);
    logic [7:0] v;
    case (i)
      4'd0: v = 8'h01;
      4'd1: v = 8'h02;
      4'd2: v = 8'h04;
      4'd3: v = 8'h08;
      4'd4: v = 8'h10;
      4'd5: v = 8'h20;
      4'd6: v = 8'h40;
      4'd7: v = 8'h80;
      4'd8: v = 8'h1b;
      4'd9: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // byte 0 sits in the top bits
  function automatic logic [7:0] get_byte(blk_t s, int i);
    return s[BLK_W-1-8*i -: 8];
  endfunction

  function automatic blk_t next_key(blk_t k, logic [3:0] step);
    logic [31:0] w0, w1, w2, w3, t, n0, n1, n2, n3;
    w0 = k[127:96];
    w1 = k[95:64];
    w2 = k[63:32];
    w3 = k[31:0];
    t  = {SBOX[w3[23:16]] ^ rcon(step), SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    n0 = w0 ^ t;
    n1 = w1 ^ n0;
    n2 = w2 ^ n1;
    n3 = w3 ^ n2;
    return {n0, n1, n2, n3};
  endfunction

  function automatic logic [7:0] xt(logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic blk_t inv_shift_sub(blk_t s);
    blk_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[BLK_W-1-8*(r+4*c) -: 8] = INV_SBOX[get_byte(s, r + 4*((c + 4 - r) % 4))];
      end
    end
    return t;
  endfunction

  function automatic blk_t inv_mix(blk_t s);
    blk_t t;
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        a[j]  = get_byte(s, 4*c + j);
        x2[j] = xt(a[j]);
        x4[j] = xt(x2[j]);
        x8[j] = xt(x4[j]);
        m9[j] = x8[j] ^ a[j];
        mb[j] = x8[j] ^ x2[j] ^ a[j];
        md[j] = x8[j] ^ x4[j] ^ a[j];
        me[j] = x8[j] ^ x4[j] ^ x2[j];
      end
      t[BLK_W-1-8*(4*c)   -: 8] = me[0] ^ mb[1] ^ md[2] ^ m9[3];
      t[BLK_W-1-8*(4*c+1) -: 8] = m9[0] ^ me[1] ^ mb[2] ^ md[3];
      t[BLK_W-1-8*(4*c+2) -: 8] = md[0] ^ m9[1] ^ me[2] ^ mb[3];
      t[BLK_W-1-8*(4*c+3) -: 8] = mb[0] ^ md[1] ^ m9[2] ^ me[3];
    end
    return t;
  endfunction

endpackage

FILE: hw/rtl/aescbc_keyexp.sv
// round key sequencer: one expansion step per cycle into a bank of 11 round keys
// depends on aescbc_pkg
module aescbc_keyexp import aescbc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  blk_t   key,
  output logic   busy,
  output rkeys_t rk
);

  localparam logic [3:0] DONE = 4'(NKEYS);

  logic [3:0] cnt_r, cnt_nxt;
  blk_t       cur_r, cur_nxt;
  rkeys_t     rk_r;

  assign busy = (cnt_r != DONE);
  assign rk   = rk_r;

  always_comb begin
    cnt_nxt = cnt_r;
    cur_nxt = cur_r;
    if (start) begin
      cnt_nxt = '0;
      cur_nxt = key;
    end else if (busy) begin
      cnt_nxt = cnt_r + 4'd1;
      cur_nxt = next_key(cur_r, cnt_r);
    end
  end

  // reset expands the all-zero key
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      cur_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      cur_r <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy && !start) begin
      rk_r[cnt_r] <= cur_r;
    end
  end

endmodule

FILE: hw/rtl/aescbc_round.sv
// one registered inverse round; the final stage skips the column mix and adds the chain value
// depends on aescbc_pkg
module aescbc_round import aescbc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     last,
  input  stg_ctl_t ctl_i,
  input  blk_t     st_i,
  input  blk_t     ch_i,
  input  blk_t     rk,
  output stg_ctl_t ctl_o,
  output blk_t     st_o,
  output blk_t     ch_o
);

  stg_ctl_t ctl_r;
  blk_t     st_r, st_nxt;
  blk_t     ch_r;
  blk_t     mid;

  always_comb begin
    mid = inv_shift_sub(st_i) ^ rk;
    if (last) begin
      st_nxt = mid ^ ch_i;
    end else begin
      st_nxt = inv_mix(mid);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
      ch_r <= ch_i;
    end
  end

  assign ctl_o = ctl_r;
  assign st_o  = st_r;
  assign ch_o  = ch_r;

endmodule

FILE: hw/rtl/aes128_cbc_decrypt_core.sv
// channel   | direction | ports
// input     | in        | in_valid, in_stall, in_cipher_hi, in_cipher_lo, in_msg_start
// result    | out       | out_valid, out_stall, out_plain_hi, out_plain_lo
// config    | in        | cfg_we, cfg_index, cfg_data
// one block per cycle while in_stall is low; entry stage plus ten round stages
// a result stalled at the output freezes the whole pipeline; nothing is dropped or repeated
// reset runs the key sequencer with in_stall high; a key write raises in_stall for the
// start pulse and then for the whole key expansion that follows it
// synchronous active-low reset clears valids, key and iv registers, chain value and key sequencer
module aes128_cbc_decrypt_core import aescbc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [63:0]          in_cipher_hi,
  input  logic [63:0]          in_cipher_lo,
  input  logic                 in_msg_start,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [63:0]          out_plain_hi,
  output logic [63:0]          out_plain_lo,
  input  logic                 cfg_we,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [63:0] key_hi_r, key_lo_r, iv_hi_r, iv_lo_r;
  logic        kstart_r;
  logic        kbusy;
  rkeys_t      rk;
  blk_t        prev_r;
  logic        en, accept;

  stg_ctl_t    ctl   [ROUNDS+1];
  blk_t        st    [ROUNDS+1];
  blk_t        ch    [ROUNDS+1];
  stg_ctl_t    s0_ctl_r;
  blk_t        s0_st_r, s0_ch_r;

  assign en       = !(ctl[ROUNDS].vld && out_stall);
  assign in_stall = !en || kbusy || kstart_r;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
      iv_hi_r  <= '0;
      iv_lo_r  <= '0;
      kstart_r <= 1'b0;
    end else begin
      kstart_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_KEY_HI: begin
            key_hi_r <= cfg_data;
            kstart_r <= 1'b1;
          end
          CFG_KEY_LO: begin
            key_lo_r <= cfg_data;
            kstart_r <= 1'b1;
          end
          CFG_IV_HI: iv_hi_r <= cfg_data;
          CFG_IV_LO: iv_lo_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  aescbc_keyexp u_keyexp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (kstart_r),
    .key   ({key_hi_r, key_lo_r}),
    .busy  (kbusy),
    .rk    (rk)
  );

  // chain value is the last ciphertext taken in
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (accept) begin
      prev_r <= {in_cipher_hi, in_cipher_lo};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_ctl_r <= '0;
    end else if (en) begin
      s0_ctl_r.vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_st_r <= {in_cipher_hi, in_cipher_lo} ^ rk[ROUNDS];
      s0_ch_r <= in_msg_start ? {iv_hi_r, iv_lo_r} : prev_r;
    end
  end

  assign ctl[0] = s0_ctl_r;
  assign st[0]  = s0_st_r;
  assign ch[0]  = s0_ch_r;

  for (genvar i = 1; i <= ROUNDS; i++) begin : g_rnd
    aescbc_round u_round (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .last  (i == ROUNDS),
      .ctl_i (ctl[i-1]),
      .st_i  (st[i-1]),
      .ch_i  (ch[i-1]),
      .rk    (rk[ROUNDS-i]),
      .ctl_o (ctl[i]),
      .st_o  (st[i]),
      .ch_o  (ch[i])
    );
  end

  assign out_valid    = ctl[ROUNDS].vld;
  assign out_plain_hi = st[ROUNDS][127:64];
  assign out_plain_lo = st[ROUNDS][63:0];

endmodule

FILE: hw/rtl/aescbc_chk.sv
// port-level checks for the aes-128 cbc decrypt core, bound to the top level
// depends on aescbc_pkg
module aescbc_chk import aescbc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [63:0]       out_plain_hi,
  input logic [63:0]       out_plain_lo
);

  // a blocked result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_plain_hi) && $stable(out_plain_lo))
    else $error("stalled result changed");

  // a blocked output freezes the pipeline, so no new transfer may enter
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output blocked");

  // reset flushes every stage; checked here on out_valid
  a_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // key expansion after reset holds off input
  a_keyhold: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input open during key expansion");

endmodule

bind aes128_cbc_decrypt_core aescbc_chk u_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_plain_hi (out_plain_hi),
  .out_plain_lo (out_plain_lo)
);
